[rtl/pgcr_pkg.sv]
// shared types and constants for the packed glyph clip renderer
package pgcr_pkg;

  localparam int LANE_STEP = 4;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 8;
  localparam int OUT_TDATA_WIDTH = 48;

  localparam logic [COORD_BITS-1:0] DEFAULT_COLOUR = 16'h8000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DRAW_COLOUR  = 3'd0,
    REG_CLIP_LEFT    = 3'd1,
    REG_CLIP_TOP     = 3'd2,
    REG_CLIP_RIGHT   = 3'd3,
    REG_CLIP_BOTTOM  = 3'd4,
    REG_GLYPH_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] bottom;
  } clip_t;

endpackage

[rtl/pgcr_walker.sv]
// column and row walker: assigns glyph coordinates to every bit lane of a word
module pgcr_walker #(
  parameter int WORD_BITS = 16,
  parameter int MAX_GLYPH_WIDTH = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [WORD_BITS-1:0]      in_word,
  input  logic                      in_start,
  input  pgcr_pkg::coord_t          in_origin_x,
  input  pgcr_pkg::coord_t          in_origin_y,
  input  pgcr_pkg::count_t          in_width,
  input  pgcr_pkg::count_t          glyph_height,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [WORD_BITS-1:0]      res_word,
  output pgcr_pkg::coord_t          res_base_x,
  output pgcr_pkg::coord_t          res_base_y,
  output pgcr_pkg::count_t          res_col [WORD_BITS],
  output pgcr_pkg::count_t          res_row [WORD_BITS],
  output logic [WORD_BITS-1:0]      res_live
);

  localparam int NSTEPS = (WORD_BITS + pgcr_pkg::LANE_STEP - 1) / pgcr_pkg::LANE_STEP;
  localparam int SW = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int RESID = WORD_BITS - (NSTEPS - 1) * pgcr_pkg::LANE_STEP;
  localparam logic [SW-1:0] LAST_STEP = SW'(NSTEPS - 1);

  logic                 busy;
  logic [SW-1:0]        step;
  pgcr_pkg::count_t     col;
  pgcr_pkg::count_t     row;
  pgcr_pkg::count_t     row_width;
  pgcr_pkg::coord_t     base_x;
  pgcr_pkg::coord_t     base_y;
  logic [WORD_BITS-1:0] word;
  pgcr_pkg::count_t     width_sat;
  pgcr_pkg::count_t     ch_col [pgcr_pkg::LANE_STEP];
  pgcr_pkg::count_t     ch_row [pgcr_pkg::LANE_STEP];
  logic [pgcr_pkg::LANE_STEP-1:0] ch_live;
  pgcr_pkg::count_t     col_next;
  pgcr_pkg::count_t     row_next;

  assign in_ready   = !busy && (!res_valid || res_ready);
  assign res_word   = word;
  assign res_base_x = base_x;
  assign res_base_y = base_y;

  always_comb begin
    width_sat = (in_width == '0) ? pgcr_pkg::count_t'(1) : in_width;
    if (32'(width_sat) > MAX_GLYPH_WIDTH) begin
      width_sat = pgcr_pkg::count_t'(MAX_GLYPH_WIDTH);
    end
  end

  // four dependent counter steps per cycle
  always_comb begin
    pgcr_pkg::count_t c;
    pgcr_pkg::count_t r;
    logic in_range;
    c = col;
    r = row;
    for (int j = 0; j < pgcr_pkg::LANE_STEP; j++) begin
      in_range = (step != LAST_STEP) || (j < RESID);
      ch_col[j] = c;
      ch_row[j] = r;
      ch_live[j] = in_range && (r < glyph_height);
      if (ch_live[j]) begin
        if ((c + 8'd1) >= row_width) begin
          c = '0;
          r = r + 8'd1;
        end else begin
          c = c + 8'd1;
        end
      end
    end
    col_next = c;
    row_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      res_valid <= 1'b0;
      base_x    <= '0;
      base_y    <= '0;
      row_width <= pgcr_pkg::count_t'(1);
      col       <= '0;
      row       <= '0;
    end else if (in_valid && in_ready) begin
      busy      <= 1'b1;
      step      <= '0;
      res_valid <= 1'b0;
      if (in_start) begin
        base_x    <= in_origin_x;
        base_y    <= in_origin_y;
        row_width <= width_sat;
        col       <= '0;
        row       <= '0;
      end
    end else if (busy) begin
      step <= step + SW'(1);
      col  <= col_next;
      row  <= row_next;
      if (step == LAST_STEP) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
    if (busy) begin
      for (int k = 0; k < WORD_BITS; k++) begin
        if (step == SW'(k / pgcr_pkg::LANE_STEP)) begin
          res_col[k]  <= ch_col[k % pgcr_pkg::LANE_STEP];
          res_row[k]  <= ch_row[k % pgcr_pkg::LANE_STEP];
          res_live[k] <= ch_live[k % pgcr_pkg::LANE_STEP];
        end
      end
    end
  end

endmodule

[rtl/pgcr_lane.sv]
// one pixel lane: target coordinates and clip test
module pgcr_lane (
  input  pgcr_pkg::coord_t                base_x,
  input  pgcr_pkg::coord_t                base_y,
  input  pgcr_pkg::count_t                col,
  input  pgcr_pkg::count_t                row,
  input  logic                            ink,
  input  logic                            live,
  input  pgcr_pkg::clip_t                 clip,
  output logic                            hit,
  output logic [pgcr_pkg::COORD_BITS-1:0] x,
  output logic [pgcr_pkg::COORD_BITS-1:0] y
);

  logic [17:0] px;
  logic [17:0] py;
  logic        in_x;
  logic        in_y;

  assign px = {{2{base_x[15]}}, base_x} + {10'd0, col};
  assign py = {{2{base_y[15]}}, base_y} + {10'd0, row};

  assign in_x = ($signed(px) >= $signed({2'b00, clip.left})) &&
                ($signed(px) <= $signed({2'b00, clip.right}));
  assign in_y = ($signed(py) >= $signed({2'b00, clip.top})) &&
                ($signed(py) <= $signed({2'b00, clip.bottom}));

  assign hit = ink && live && in_x && in_y;
  assign x   = px[15:0];
  assign y   = py[15:0];

endmodule

[rtl/pgcr_merge.sv]
// merging stage: holds lane hits, sends a pixel write per cycle unless stalled
module pgcr_merge #(
  parameter int WORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [WORD_BITS-1:0]            in_hit,
  input  logic [pgcr_pkg::COORD_BITS-1:0] in_x [WORD_BITS],
  input  logic [pgcr_pkg::COORD_BITS-1:0] in_y [WORD_BITS],
  input  logic [pgcr_pkg::COORD_BITS-1:0] colour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pgcr_pkg::COORD_BITS-1:0] out_x,
  output logic [pgcr_pkg::COORD_BITS-1:0] out_y,
  output logic [pgcr_pkg::COORD_BITS-1:0] out_colour,
  output logic                            out_last
);

  localparam int IW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0]            hits;
  logic [pgcr_pkg::COORD_BITS-1:0] xs [WORD_BITS];
  logic [pgcr_pkg::COORD_BITS-1:0] ys [WORD_BITS];
  logic [IW-1:0]                   sel;
  logic [WORD_BITS-1:0]            hits_next;
  logic                            pop;

  // lowest lane first; lane 0 carries the word's most significant bit
  always_comb begin
    sel = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (hits[k]) begin
        sel = IW'(k);
      end
    end
  end

  assign hits_next = hits & ~(WORD_BITS'(1) << sel);
  assign pop       = (hits != '0) && (!out_valid || out_ready);
  assign in_ready  = (hits == '0) || (pop && (hits_next == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hits <= in_hit;
      end else if (pop) begin
        hits <= hits_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      xs <= in_x;
      ys <= in_y;
    end
    if (pop) begin
      out_x      <= xs[sel];
      out_y      <= ys[sel];
      out_colour <= colour;
      out_last   <= (hits_next == '0);
    end
  end

endmodule

[rtl/packed_glyph_clip_renderer.sv]
// top level of the packed glyph clip renderer
//
//  port group  dir  transaction contents
//  s_*         in   s_tdata: bit_word, origin_x, origin_y, glyph_width; s_tuser: glyph_start
//  m_*         out  m_tdata: write_x, write_y, write_colour; m_tlast: last_of_word
//  cfg_*       in   cfg_index selects draw_colour .. glyph_height, cfg_data is the value
//
//  a word is taken, then walked four bit lanes a cycle; the next word is not taken
//  until the walk is through and its result is passed on to the merger
//  all lanes clip at once, then the merger sends one pixel write per cycle unless stalled
//  the writes of a word leave without a gap, and the next word is walked meanwhile
//  reset is synchronous, clears counters and both valid flags, loads configuration defaults
//  a stall on m_tready holds the output register and backs up to s_tready
module packed_glyph_clip_renderer #(
  parameter int WORD_BITS = 16,
  parameter int MAX_GLYPH_WIDTH = 255
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // bit_word, origin_x, origin_y, glyph_width, zero padding
  input  logic [((WORD_BITS + 40 + 7) / 8) * 8 - 1:0] s_tdata,
  // glyph_start
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // write_x, write_y, write_colour
  output logic [pgcr_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [pgcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pgcr_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int OX_LO = WORD_BITS;
  localparam int OY_LO = WORD_BITS + 16;
  localparam int GW_LO = WORD_BITS + 32;

  logic [15:0]            draw_colour;
  pgcr_pkg::clip_t        clip;
  pgcr_pkg::count_t       glyph_height;
  logic [15:0]            colour;

  logic                   res_valid;
  logic                   res_ready;
  logic [WORD_BITS-1:0]   res_word;
  pgcr_pkg::coord_t       res_base_x;
  pgcr_pkg::coord_t       res_base_y;
  pgcr_pkg::count_t       res_col [WORD_BITS];
  pgcr_pkg::count_t       res_row [WORD_BITS];
  logic [WORD_BITS-1:0]   res_live;
  logic [WORD_BITS-1:0]   lane_hit;
  logic [15:0]            lane_x [WORD_BITS];
  logic [15:0]            lane_y [WORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_colour  <= '0;
      clip.left    <= '0;
      clip.top     <= '0;
      clip.right   <= 16'hffff;
      clip.bottom  <= 16'hffff;
      glyph_height <= 8'd8;
    end else if (cfg_we) begin
      case (pgcr_pkg::cfg_reg_t'(cfg_index))
        pgcr_pkg::REG_DRAW_COLOUR:  draw_colour  <= cfg_data;
        pgcr_pkg::REG_CLIP_LEFT:    clip.left    <= cfg_data;
        pgcr_pkg::REG_CLIP_TOP:     clip.top     <= cfg_data;
        pgcr_pkg::REG_CLIP_RIGHT:   clip.right   <= cfg_data;
        pgcr_pkg::REG_CLIP_BOTTOM:  clip.bottom  <= cfg_data;
        pgcr_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign colour = (draw_colour == '0) ? pgcr_pkg::DEFAULT_COLOUR : draw_colour;

  pgcr_walker #(
    .WORD_BITS       (WORD_BITS),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_word      (s_tdata[WORD_BITS-1:0]),
    .in_start     (s_tuser),
    .in_origin_x  (s_tdata[OX_LO+15:OX_LO]),
    .in_origin_y  (s_tdata[OY_LO+15:OY_LO]),
    .in_width     (s_tdata[GW_LO+7:GW_LO]),
    .glyph_height (glyph_height),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_word     (res_word),
    .res_base_x   (res_base_x),
    .res_base_y   (res_base_y),
    .res_col      (res_col),
    .res_row      (res_row),
    .res_live     (res_live)
  );

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_lane
    pgcr_lane u_lane (
      .base_x (res_base_x),
      .base_y (res_base_y),
      .col    (res_col[k]),
      .row    (res_row[k]),
      .ink    (res_word[WORD_BITS-1-k]),
      .live   (res_live[k]),
      .clip   (clip),
      .hit    (lane_hit[k]),
      .x      (lane_x[k]),
      .y      (lane_y[k])
    );
  end

  pgcr_merge #(
    .WORD_BITS (WORD_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (res_valid),
    .in_ready   (res_ready),
    .in_hit     (lane_hit),
    .in_x       (lane_x),
    .in_y       (lane_y),
    .colour     (colour),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (m_tdata[15:0]),
    .out_y      (m_tdata[31:16]),
    .out_colour (m_tdata[47:32]),
    .out_last   (m_tlast)
  );

endmodule

[rtl/pgcr_checker.sv]
// port checker for the packed glyph clip renderer and its bind
module pgcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_word_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside the writes of one word");

  a_colour_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:32] != 16'h0000)
    else $error("zero colour written");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind packed_glyph_clip_renderer pgcr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
